// ===== design/egrr_pkg.sv =====
// shared types and constants for the event group round robin waiter
`timescale 1ns / 1ps

package egrr_pkg;

    localparam int OP_W       = 3;
    localparam int FIDX_W     = 6;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_RESET = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_SET    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_RESET  = 3'd2,
        OP_TERM   = 3'd3,
        OP_TRY    = 3'd4,
        OP_BEGIN  = 3'd5,
        OP_FINISH = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_ACK     = 3'd0,
        ST_ONE     = 3'd1,
        ST_ALL     = 3'd2,
        ST_NONE    = 3'd3,
        ST_TERM    = 3'd4,
        ST_TIMEOUT = 3'd5,
        ST_IGNORED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_ALL  = 2'd2
    } t_mode;

    typedef struct packed {
        logic load_cand;
        logic capture;
        logic commit;
    } t_ctl_cmd;

endpackage

// ===== design/egrr_in_if.sv =====
// operation channel interface
`timescale 1ns / 1ps

interface egrr_in_if;
    logic                        valid;
    logic                        ready;
    logic [egrr_pkg::OP_W-1:0]   opcode;
    logic [egrr_pkg::FIDX_W-1:0] flag_index;
    logic                        wait_all;
    logic                        timed_out;

    modport source (output valid, output opcode, output flag_index, output wait_all,
                    output timed_out, input ready);
    modport sink (input valid, input opcode, input flag_index, input wait_all,
                  input timed_out, output ready);
endinterface

// ===== design/egrr_out_if.sv =====
// result channel interface
`timescale 1ns / 1ps

interface egrr_out_if;
    logic                        valid;
    logic                        ready;
    logic [egrr_pkg::STAT_W-1:0] status;
    logic [egrr_pkg::FIDX_W-1:0] granted_index;
    logic                        wake;

    modport source (output valid, output status, output granted_index, output wake,
                    input ready);
    modport sink (input valid, input status, input granted_index, input wake,
                  output ready);
endinterface

// ===== design/egrr_ctrl.sv =====
// control state machine: accept, execute, output register handshake
`timescale 1ns / 1ps

module egrr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output egrr_pkg::t_ctl_cmd o_cmd
);
    import egrr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_cmd.load_cand = (r_state == S_IDLE);
    assign o_cmd.capture   = accept;
    assign o_cmd.commit    = commit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/egrr_dpath.sv =====
// flag state, round robin search and result register
`timescale 1ns / 1ps

module egrr_dpath #(
    parameter int MAX_EVENTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  egrr_pkg::t_ctl_cmd                i_cmd,
    input  logic                              i_cfg_we,
    input  logic [egrr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [egrr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [egrr_pkg::OP_W-1:0]         i_opcode,
    input  logic [egrr_pkg::FIDX_W-1:0]       i_flag_index,
    input  logic                              i_wait_all,
    input  logic                              i_timed_out,
    output logic [egrr_pkg::STAT_W-1:0]       o_status,
    output logic [egrr_pkg::FIDX_W-1:0]       o_granted_index,
    output logic                              o_wake
);
    import egrr_pkg::*;

    localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);

    logic [MAX_EVENTS-1:0] r_flags, n_flags;
    logic [IW-1:0]         r_last, n_last;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_manual, n_manual;
    logic                  r_term, n_term;
    t_mode                 r_mode, n_mode;
    logic                  r_wake, n_wake;

    t_op                   r_op;
    logic [FIDX_W-1:0]     r_fidx;
    logic                  r_all;
    logic                  r_tmo;
    logic [MAX_EVENTS-1:0] r_cand, n_cand;

    t_status               r_status, n_status;
    logic [FIDX_W-1:0]     r_gidx, n_gidx;
    logic                  r_owake;

    logic [MAX_EVENTS-1:0] use_mask;
    logic [MAX_EVENTS-1:0] hi_mask;
    logic [MAX_EVENTS-1:0] hi_flags;
    logic [MAX_EVENTS-1:0] cfg_mask;
    logic [MAX_EVENTS-1:0] fbit;
    logic [MAX_EVENTS-1:0] set_flags;
    logic [CW-1:0]         cfg_eff;
    logic [IW-1:0]         sel_idx;
    logic                  found;
    logic                  idx_bad;
    logic                  all_now;
    logic                  all_after_set;

    // candidate vector for the round robin grant, built while idle
    always_comb begin
        for (int i = 0; i < MAX_EVENTS; i++) begin
            use_mask[i] = (CW'(i) < r_count);
            hi_mask[i]  = (IW'(i) > r_last);
            cfg_mask[i] = (CW'(i) < cfg_eff);
        end
        hi_flags = r_flags & hi_mask;
        n_cand   = (|hi_flags) ? hi_flags : r_flags;
    end

    // lowest set bit of the candidate
    always_comb begin
        sel_idx = '0;
        for (int i = MAX_EVENTS - 1; i >= 0; i--) begin
            if (r_cand[i]) begin
                sel_idx = IW'(i);
            end
        end
        found = |r_cand;
    end

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_eff = CW'(1);
        end else if (i_cfg_data > CFG_DATA_W'(MAX_EVENTS)) begin
            cfg_eff = CW'(MAX_EVENTS);
        end else begin
            cfg_eff = CW'(i_cfg_data);
        end
    end

    assign idx_bad       = (CFG_DATA_W'(r_fidx) >= CFG_DATA_W'(r_count));
    assign fbit          = MAX_EVENTS'(1) << r_fidx;
    assign set_flags     = r_flags | fbit;
    assign all_now       = ((r_flags & use_mask) == use_mask);
    assign all_after_set = ((set_flags & use_mask) == use_mask);

    always_comb begin
        n_flags  = r_flags;
        n_last   = r_last;
        n_count  = r_count;
        n_manual = r_manual;
        n_term   = r_term;
        n_mode   = r_mode;
        n_wake   = r_wake;
        n_status = ST_ACK;
        n_gidx   = '0;
        if (i_cmd.commit) begin
            case (r_op)
                OP_SET: begin
                    if (idx_bad) begin
                        n_status = ST_IGNORED;
                    end else begin
                        n_flags = set_flags;
                        if (r_mode == MODE_ONE || (r_mode == MODE_ALL && all_after_set)) begin
                            n_wake = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    if (idx_bad) begin
                        n_status = ST_IGNORED;
                    end else begin
                        n_flags = r_flags & ~fbit;
                        if ((r_flags & ~fbit) == '0) begin
                            n_wake = 1'b0;
                        end
                    end
                end
                OP_RESET: begin
                    n_flags = '0;
                    n_last  = IW'(r_count - CW'(1));
                    n_term  = 1'b0;
                    n_wake  = 1'b0;
                    n_mode  = MODE_IDLE;
                end
                OP_TERM: begin
                    n_term = 1'b1;
                    n_wake = 1'b1;
                end
                OP_TRY, OP_BEGIN: begin
                    if (r_term) begin
                        n_status = ST_TERM;
                    end else if (!r_all && found) begin
                        n_last   = sel_idx;
                        n_gidx   = FIDX_W'(sel_idx);
                        n_status = ST_ONE;
                        if (!r_manual) begin
                            n_flags = r_flags & ~(MAX_EVENTS'(1) << sel_idx);
                        end
                    end else if (r_all && (r_flags != '0) && all_now) begin
                        n_status = ST_ALL;
                        if (!r_manual) begin
                            n_flags = '0;
                        end
                    end else begin
                        n_mode   = r_all ? MODE_ALL : MODE_ONE;
                        n_wake   = 1'b0;
                        n_status = ST_NONE;
                    end
                    if (r_op == OP_TRY) begin
                        n_mode = MODE_IDLE;
                    end
                end
                OP_FINISH: begin
                    n_mode = MODE_IDLE;
                    if (r_term) begin
                        n_status = ST_TERM;
                    end else if (r_tmo) begin
                        n_status = ST_TIMEOUT;
                    end else if (r_all) begin
                        n_status = ST_ALL;
                        if (!r_manual) begin
                            n_flags = '0;
                        end
                    end else if (found) begin
                        n_last   = sel_idx;
                        n_gidx   = FIDX_W'(sel_idx);
                        n_status = ST_ONE;
                        if (!r_manual) begin
                            n_flags = r_flags & ~(MAX_EVENTS'(1) << sel_idx);
                        end
                    end else begin
                        n_status = ST_NONE;
                    end
                end
                default: n_status = ST_ACK;
            endcase
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EVENT_COUNT: begin
                    n_count = cfg_eff;
                    n_last  = IW'(cfg_eff - CW'(1));
                    n_flags = r_flags & cfg_mask;
                end
                CFG_MANUAL_RESET: begin
                    n_manual = i_cfg_data[0];
                end
                default: n_manual = r_manual;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_last   <= IW'(MAX_EVENTS - 1);
            r_count  <= CW'(MAX_EVENTS);
            r_manual <= 1'b0;
            r_term   <= 1'b0;
            r_mode   <= MODE_IDLE;
            r_wake   <= 1'b0;
        end else begin
            r_flags  <= n_flags;
            r_last   <= n_last;
            r_count  <= n_count;
            r_manual <= n_manual;
            r_term   <= n_term;
            r_mode   <= n_mode;
            r_wake   <= n_wake;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cand) begin
            r_cand <= n_cand;
        end
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_opcode);
            r_fidx <= i_flag_index;
            r_all  <= i_wait_all;
            r_tmo  <= i_timed_out;
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_gidx   <= n_gidx;
            r_owake  <= n_wake;
        end
    end

    assign o_status        = r_status;
    assign o_granted_index = r_gidx;
    assign o_wake          = r_owake;

endmodule

// ===== design/event_group_round_robin_waiter.sv =====
// top level of the event flag group with round robin waiter
//
//   channel   dir  beat fields
//   i_evt     in   opcode, flag_index, wait_all, timed_out
//   o_res     out  status, granted_index, wake
//   i_cfg_*   in   register index, write data (no handshake)
//
// a beat is taken in the idle state while the round robin candidate vector
// is registered; the exec state then encodes it and updates the flags.
// reset is synchronous; afterwards all flags are clear and the count is MAX_EVENTS.
// a result waits in the output register; the next beat is still taken, and
// execution holds until that register is free.
`timescale 1ns / 1ps

module event_group_round_robin_waiter #(
    parameter int MAX_EVENTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [egrr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [egrr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    egrr_in_if.sink                         i_evt,
    egrr_out_if.source                      o_res
);
    import egrr_pkg::*;

    t_ctl_cmd cmd;

    egrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (i_evt.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    egrr_dpath #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_evt.opcode),
        .i_flag_index    (i_evt.flag_index),
        .i_wait_all      (i_evt.wait_all),
        .i_timed_out     (i_evt.timed_out),
        .o_status        (o_res.status),
        .o_granted_index (o_res.granted_index),
        .o_wake          (o_res.wake)
    );

endmodule

// ===== test/egrr_checker.sv =====
// checker for the event group round robin waiter: watches both channels and predicts every result
`timescale 1ns / 1ps

module egrr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [egrr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [egrr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    egrr_in_if                              i_evt,
    egrr_out_if                             i_res,
    output int                              o_errors,
    output int                              o_pending
);
    import egrr_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [FIDX_W-1:0]      index;
        logic                   wake;
    } t_answer;

    logic [63:0]       flags;
    logic [FIDX_W-1:0] last_grant;
    logic              terminating;
    t_mode             mode;
    logic              wake;
    int unsigned       count;
    logic              manual;
    t_answer           answers_due[$];

    task automatic report_mismatch(input string msg);
        o_errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function automatic logic [63:0] used_mask();
        if (count >= 64) begin
            return '1;
        end
        return (64'd1 << count) - 64'd1;
    endfunction

    function automatic bit all_in_use_set();
        return (flags & used_mask()) == used_mask();
    endfunction

    task automatic rr_search(output bit found, output logic [FIDX_W-1:0] idx);
        int unsigned i;
        found = 1'b0;
        idx   = '0;
        for (int unsigned k = 1; k <= count; k++) begin
            i = (last_grant + k) % count;
            if (flags[i]) begin
                last_grant = i[FIDX_W-1:0];
                idx        = i[FIDX_W-1:0];
                found      = 1'b1;
                return;
            end
        end
    endtask

    task automatic try_grant(input logic all, output t_status st,
                             output logic [FIDX_W-1:0] gi);
        bit hit;
        gi = '0;
        if (terminating) begin
            st = ST_TERM;
            return;
        end
        if (flags != '0) begin
            if (!all) begin
                rr_search(hit, gi);
                if (hit) begin
                    if (!manual) flags[gi] = 1'b0;
                    st = ST_ONE;
                    return;
                end
            end else if (all_in_use_set()) begin
                if (!manual) flags = '0;
                st = ST_ALL;
                return;
            end
        end
        mode = all ? MODE_ALL : MODE_ONE;
        wake = 1'b0;
        st   = ST_NONE;
    endtask

    task automatic execute_op(input logic [OP_W-1:0] op, input logic [FIDX_W-1:0] fi,
                              input logic all, input logic tmo, output t_answer ans);
        t_status           st;
        logic [FIDX_W-1:0] gi;
        bit                hit;
        st = ST_ACK;
        gi = '0;
        case (op)
            OP_SET: begin
                if (fi >= count) begin
                    st = ST_IGNORED;
                end else begin
                    flags[fi] = 1'b1;
                    if (mode == MODE_ONE || (mode == MODE_ALL && all_in_use_set())) wake = 1'b1;
                end
            end
            OP_CLEAR: begin
                if (fi >= count) begin
                    st = ST_IGNORED;
                end else begin
                    flags[fi] = 1'b0;
                    if (flags == '0) wake = 1'b0;
                end
            end
            OP_RESET: begin
                flags       = '0;
                last_grant  = FIDX_W'(count - 1);
                terminating = 1'b0;
                wake        = 1'b0;
                mode        = MODE_IDLE;
            end
            OP_TERM: begin
                terminating = 1'b1;
                wake        = 1'b1;
            end
            OP_TRY, OP_BEGIN: begin
                try_grant(all, st, gi);
                if (op == OP_TRY) mode = MODE_IDLE;
            end
            OP_FINISH: begin
                mode = MODE_IDLE;
                if (terminating) begin
                    st = ST_TERM;
                end else if (tmo) begin
                    st = ST_TIMEOUT;
                end else if (all) begin
                    if (!manual) flags = '0;
                    st = ST_ALL;
                end else begin
                    rr_search(hit, gi);
                    if (hit) begin
                        if (!manual) flags[gi] = 1'b0;
                        st = ST_ONE;
                    end else begin
                        st = ST_NONE;
                    end
                end
            end
            default: begin
            end
        endcase
        if (st != ST_ONE) gi = '0;
        ans.status = st;
        ans.index  = gi;
        ans.wake   = wake;
    endtask

    always @(posedge i_clk) begin
        t_answer due;
        t_answer fresh;
        if (!i_rst_n) begin
            count       = 64;
            manual      = 1'b0;
            flags       = '0;
            last_grant  = FIDX_W'(63);
            terminating = 1'b0;
            mode        = MODE_IDLE;
            wake        = 1'b0;
            answers_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                              i_res.status));
                end else begin
                    due = answers_due.pop_front();
                    if (i_res.status !== due.status)
                        report_mismatch($sformatf("status expected %0d got %0d",
                                                  due.status, i_res.status));
                    if (i_res.granted_index !== due.index)
                        report_mismatch($sformatf("granted_index expected %0d got %0d",
                                                  due.index, i_res.granted_index));
                    if (i_res.wake !== due.wake)
                        report_mismatch($sformatf("wake expected %0d got %0d",
                                                  due.wake, i_res.wake));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EVENT_COUNT: begin
                        if (i_cfg_data == '0) count = 1;
                        else if (i_cfg_data > 64) count = 64;
                        else count = i_cfg_data;
                        last_grant = FIDX_W'(count - 1);
                        flags      = flags & used_mask();
                    end
                    CFG_MANUAL_RESET: begin
                        manual = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_evt.valid && i_evt.ready) begin
                execute_op(i_evt.opcode, i_evt.flag_index, i_evt.wait_all, i_evt.timed_out,
                           fresh);
                answers_due.push_back(fresh);
            end
        end
        o_pending = answers_due.size();
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the event group round robin waiter: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_top;
    import egrr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 72;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    bit hold_go;
    int sent;
    int count_now;
    int quiet;
    int phase_count[8] = '{1, 5, 64, 0, 127, 13, 2, 64};

    egrr_in_if  evt_if ();
    egrr_out_if res_if ();

    event_group_round_robin_waiter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_evt      (evt_if),
        .o_res      (res_if)
    );

    egrr_checker u_flag_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_evt      (evt_if),
        .i_res      (res_if),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result side: random stalls plus a long hold-off on request
    initial begin : receiver
        bit seen;
        int left;
        seen = 1'b0;
        left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go != seen) begin
                seen = hold_go;
                left = HOLD_CYCLES;
            end
            if (left != 0) begin
                left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_op(input logic [OP_W-1:0] op, input logic [FIDX_W-1:0] idx,
                           input logic all, input logic tmo);
        while ($urandom_range(0, 99) < idle_pct) begin
            evt_if.valid      <= 1'b0;
            evt_if.opcode     <= OP_W'($urandom_range(0, 7));
            evt_if.flag_index <= FIDX_W'($urandom_range(0, 63));
            evt_if.wait_all   <= 1'($urandom_range(0, 1));
            evt_if.timed_out  <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        evt_if.valid      <= 1'b1;
        evt_if.opcode     <= op;
        evt_if.flag_index <= idx;
        evt_if.wait_all   <= all;
        evt_if.timed_out  <= tmo;
        do @(posedge i_clk); while (!evt_if.ready);
        sent++;
    endtask

    // stop offering and wait until every beat has come back
    task automatic drain();
        evt_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(data);
        if (idx == CFG_EVENT_COUNT) begin
            count_now = (data == 0) ? 1 : (data > 64) ? 64 : data;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [FIDX_W-1:0] any_flag();
        return FIDX_W'($urandom_range(0, count_now - 1));
    endfunction

    function automatic logic [FIDX_W-1:0] junk_idx();
        return FIDX_W'($urandom_range(0, 63));
    endfunction

    task automatic random_sequence();
        int   r;
        int   n;
        logic all;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            n = $urandom_range(1, 4);
            repeat (n) send_op(OP_SET, any_flag(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                send_op(OP_CLEAR, any_flag(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            all = ($urandom_range(0, 3) == 0);
            send_op($urandom_range(0, 1) ? OP_TRY : OP_BEGIN, junk_idx(), all,
                    1'($urandom_range(0, 1)));
        end else if (r < 70) begin
            all = 1'($urandom_range(0, 1));
            send_op(OP_BEGIN, junk_idx(), all, 1'($urandom_range(0, 1)));
            n = $urandom_range(0, 3);
            repeat (n) send_op(OP_SET, any_flag(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            send_op(OP_FINISH, junk_idx(), all, ($urandom_range(0, 4) == 0));
        end else if (r < 80 && count_now <= 8) begin
            for (int i = 0; i < count_now; i++) send_op(OP_SET, FIDX_W'(i), 1'b0, 1'b0);
            case ($urandom_range(0, 2))
                0: send_op(OP_TRY, junk_idx(), 1'b1, 1'b0);
                1: send_op(OP_BEGIN, junk_idx(), 1'b1, 1'b0);
                default: send_op(OP_FINISH, junk_idx(), 1'b1, 1'b0);
            endcase
        end else begin
            n = $urandom_range(0, 7);
            send_op(OP_W'(n), junk_idx(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (n == OP_TERM) begin
                send_op($urandom_range(0, 1) ? OP_TRY : OP_FINISH, junk_idx(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                send_op(OP_RESET, junk_idx(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : stimulus
        int target;
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_EVENT_COUNT;
        cfg_data          <= '0;
        hold_go           <= 1'b0;
        evt_if.valid      <= 1'b0;
        evt_if.opcode     <= OP_SET;
        evt_if.flag_index <= '0;
        evt_if.wait_all   <= 1'b0;
        evt_if.timed_out  <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        sent      = 0;
        count_now = 64;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults, count 64, flags cleared on grant
        send_op(OP_TRY, 6'd0, 1'b0, 1'b0);
        send_op(OP_SET, 6'd0, 1'b0, 1'b0);
        send_op(OP_SET, 6'd63, 1'b1, 1'b1);
        send_op(OP_TRY, 6'd0, 1'b0, 1'b0);
        send_op(OP_BEGIN, 6'd0, 1'b0, 1'b0);
        send_op(OP_BEGIN, 6'd0, 1'b0, 1'b0);
        send_op(OP_SET, 6'd10, 1'b0, 1'b0);
        send_op(OP_FINISH, 6'd0, 1'b0, 1'b0);
        send_op(OP_BEGIN, 6'd0, 1'b1, 1'b0);
        send_op(OP_SET, 6'd5, 1'b0, 1'b0);
        send_op(OP_FINISH, 6'd0, 1'b1, 1'b1);
        send_op(OP_FINISH, 6'd0, 1'b1, 1'b0);
        send_op(OP_CLEAR, 6'd5, 1'b0, 1'b0);
        send_op(OP_TERM, 6'd0, 1'b0, 1'b0);
        send_op(OP_TRY, 6'd0, 1'b1, 1'b0);
        send_op(OP_FINISH, 6'd0, 1'b0, 1'b1);
        send_op(OP_RESET, 6'd0, 1'b0, 1'b0);
        send_op(OP_UNUSED, 6'd63, 1'b1, 1'b1);

        // directed: small group, flags kept after a grant, indexes out of range
        write_reg(CFG_EVENT_COUNT, 3);
        write_reg(CFG_MANUAL_RESET, 1);
        send_op(OP_SET, 6'd3, 1'b0, 1'b0);
        send_op(OP_CLEAR, 6'd63, 1'b0, 1'b0);
        send_op(OP_SET, 6'd0, 1'b0, 1'b0);
        send_op(OP_SET, 6'd1, 1'b0, 1'b0);
        send_op(OP_SET, 6'd2, 1'b0, 1'b0);
        send_op(OP_BEGIN, 6'd0, 1'b1, 1'b0);
        send_op(OP_TRY, 6'd0, 1'b0, 1'b0);
        send_op(OP_TRY, 6'd0, 1'b0, 1'b0);

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_EVENT_COUNT, phase_count[p]);
            write_reg(CFG_MANUAL_RESET, p % 2);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            target = sent + ITEMS_PER_PHASE;
            if (p == 2) begin
                // long hold-off on results while operations keep coming
                idle_pct = 0;
                hold_go <= ~hold_go;
                repeat (20) random_sequence();
                idle_pct = 0;
                drain();
            end
            while (sent < target) random_sequence();
        end

        drain();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
